@@ src/ptd_pkg.sv @@
`timescale 1ns / 1ps
package ptd_pkg;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CHECK,
		OP_QMAC,
		OP_QSAT,
		OP_SQMAC,
		OP_SQRT_N,
		OP_ST_N,
		OP_WMUL,
		OP_SQRT_Y,
		OP_COR,
		OP_ANGLE,
		OP_LMUL,
		OP_DIV_L,
		OP_ST_L,
		OP_RMUL,
		OP_DIV_R,
		OP_ST_R,
		OP_AMUL,
		OP_DIV_A,
		OP_ST_A,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] idx;
	} cmd_t;

	typedef struct packed {
		logic first;
		logic zero_dt;
		logic small_norm;
		logic div_busy;
		logic sqrt_busy;
		logic cor_busy;
	} sts_t;

	localparam logic [1:0] ST_FIRST    = 2'd0;
	localparam logic [1:0] ST_ZERO_DT  = 2'd1;
	localparam logic [1:0] ST_COMPUTED = 2'd2;

	localparam logic [4:0] Q_TERMS = 5'd16;
	localparam logic [4:0] E_LAST  = 5'd2;

	localparam logic signed [33:0] USEC_PER_SEC = 34'sd1000000;
	localparam logic [31:0]        NORM_EPS     = 32'd107374;
	localparam logic signed [35:0] ONE_Q30      = 36'sd1073741824;
	localparam logic signed [34:0] PI_Q30       = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30  = 35'sd1686629713;
	localparam logic signed [34:0] TWO_PI_Q30   = 35'sd6746518852;
	localparam logic [4:0]         CORDIC_STEPS = 5'd30;
	localparam logic [63:0]        SQRT_TOP     = 64'h4000_0000_0000_0000;
	localparam logic [63:0]        ONE_SQ_Q60   = 64'h1000_0000_0000_0000;

	// Term of the error quaternion product: {negate, prev index, current index}.
	function automatic logic [4:0] qterm(input logic [3:0] t);
		logic [4:0] r;
		case (t)
			4'd0:    r = {1'b0, 2'd0, 2'd0};
			4'd1:    r = {1'b0, 2'd1, 2'd1};
			4'd2:    r = {1'b0, 2'd2, 2'd2};
			4'd3:    r = {1'b0, 2'd3, 2'd3};
			4'd4:    r = {1'b1, 2'd0, 2'd1};
			4'd5:    r = {1'b0, 2'd1, 2'd0};
			4'd6:    r = {1'b1, 2'd2, 2'd3};
			4'd7:    r = {1'b0, 2'd3, 2'd2};
			4'd8:    r = {1'b1, 2'd0, 2'd2};
			4'd9:    r = {1'b0, 2'd1, 2'd3};
			4'd10:   r = {1'b0, 2'd2, 2'd0};
			4'd11:   r = {1'b1, 2'd3, 2'd1};
			4'd12:   r = {1'b1, 2'd0, 2'd3};
			4'd13:   r = {1'b1, 2'd1, 2'd2};
			4'd14:   r = {1'b0, 2'd2, 2'd1};
			default: r = {1'b0, 2'd3, 2'd0};
		endcase
		return r;
	endfunction

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'h3243F6A8;
			5'd1:    r = 32'h1DAC6705;
			5'd2:    r = 32'h0FADBAFC;
			5'd3:    r = 32'h07F56EA6;
			5'd4:    r = 32'h03FEAB76;
			5'd5:    r = 32'h01FFD55B;
			5'd6:    r = 32'h00FFFAAA;
			5'd7:    r = 32'h007FFF55;
			5'd8:    r = 32'h003FFFEA;
			5'd9:    r = 32'h001FFFFD;
			5'd10:   r = 32'h000FFFFF;
			5'd11:   r = 32'h0007FFFF;
			5'd12:   r = 32'h0003FFFF;
			5'd13:   r = 32'h0001FFFF;
			5'd14:   r = 32'h0000FFFF;
			5'd15:   r = 32'h00007FFF;
			5'd16:   r = 32'h00003FFF;
			5'd17:   r = 32'h00001FFF;
			5'd18:   r = 32'h00000FFF;
			5'd19:   r = 32'h000007FF;
			5'd20:   r = 32'h000003FF;
			5'd21:   r = 32'h000001FF;
			5'd22:   r = 32'h000000FF;
			5'd23:   r = 32'h0000007F;
			5'd24:   r = 32'h0000003F;
			5'd25:   r = 32'h0000001F;
			5'd26:   r = 32'h0000000F;
			5'd27:   r = 32'h00000008;
			5'd28:   r = 32'h00000004;
			5'd29:   r = 32'h00000002;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

@@ src/ptd_datapath.sv @@
`timescale 1ns / 1ps
module ptd_datapath #(
	parameter int SW = 48,
	parameter int PW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ptd_pkg::cmd_t         cmd,
	output ptd_pkg::sts_t         sts,
	input  logic [SW-1:0]         stamp_us,
	input  logic signed [PW-1:0]  pos_x,
	input  logic signed [PW-1:0]  pos_y,
	input  logic signed [PW-1:0]  pos_z,
	input  logic signed [31:0]    quat_w,
	input  logic signed [31:0]    quat_x,
	input  logic signed [31:0]    quat_y,
	input  logic signed [31:0]    quat_z,
	output logic [SW-1:0]         out_stamp_us,
	output logic signed [31:0]    lin_x,
	output logic signed [31:0]    lin_y,
	output logic signed [31:0]    lin_z,
	output logic signed [31:0]    ang_x,
	output logic signed [31:0]    ang_y,
	output logic signed [31:0]    ang_z,
	output logic [1:0]            status
);
	import ptd_pkg::*;

	localparam int MA  = (PW + 2 > 35) ? PW + 2 : 35;
	localparam int PRW = MA + 34;
	localparam int NW  = (PW + 20 > 64) ? PW + 20 : 64;
	localparam int DW  = (SW > 32) ? SW : 32;
	localparam int NCW = $clog2(NW + 1);

	// Current and previous pose.
	logic [SW-1:0]        cur_stamp_q, prev_stamp_q;
	logic signed [PW-1:0] cur_pos_q [3];
	logic signed [PW-1:0] prev_pos_q [3];
	logic signed [31:0]   cur_quat_q [4];
	logic signed [31:0]   prev_quat_q [4];
	logic                 first_q;
	logic                 dneg_q;
	logic [SW-1:0]        dmag_q;

	logic signed [PRW-1:0] prod_q;
	logic signed [35:0]    acc_q [4];
	logic signed [32:0]    e_q [3];
	logic [63:0]           ss_q;
	logic [31:0]           norm_q;
	logic [30:0]           xabs_q;
	logic                  wneg_q;
	logic signed [34:0]    angle_q;
	logic signed [34:0]    r_q [3];

	logic [63:0] sq_v_q, sq_res_q, sq_one_q;
	logic [5:0]  sq_cnt_q;

	logic signed [34:0] cx_q, cy_q, cz_q;
	logic [4:0]         cor_i_q;
	logic               cor_busy_q;

	logic [NW-1:0]  dv_num_q, dv_quo_q;
	logic [DW-1:0]  dv_rem_q, dv_den_q;
	logic [NCW-1:0] dv_cnt_q;
	logic           dv_neg_q;

	logic [SW-1:0]      res_stamp_q;
	logic [1:0]         res_status_q;
	logic signed [31:0] res_lin_q [3];
	logic signed [31:0] res_ang_q [3];

	function automatic logic [31:0] sat_rate(input logic [NW-1:0] q, input logic neg);
		logic big;
		big = |q[NW-1:31];
		if (neg)
			return big ? 32'h8000_0000 : 32'd0 - q[31:0];
		return big ? 32'h7FFF_FFFF : q[31:0];
	endfunction

	function automatic logic signed [32:0] sat_e(input logic signed [35:0] v);
		if (v > 36'sd2147483647)
			return 33'sd2147483647;
		if (v < -36'sd2147483648)
			return -33'sd2147483648;
		return v[32:0];
	endfunction

	logic [1:0]            ci;
	logic [4:0]            qt, tq;
	logic [3:0]            tm;
	logic signed [MA-1:0]  mul_a;
	logic signed [33:0]    mul_b;
	logic signed [PW:0]    dpos;
	logic [PW:0]           dpos_mag;
	logic [34:0]           r_mag;
	logic signed [PRW-1:0] pn, pabs;
	logic signed [35:0]    term;
	logic signed [35:0]    ew, wc;
	logic [30:0]           xabs;
	logic signed [34:0]    zc, th, a2;
	logic [64:0]           sq_sum;
	logic                  sq_ge;
	logic signed [34:0]    cxs, cys;
	logic [DW:0]           rem_sh;
	logic                  dv_ge;

	always_comb begin
		ci       = cmd.idx[1:0];
		qt       = qterm(cmd.idx[3:0]);
		tm       = 4'(cmd.idx - 5'd1);
		tq       = qterm(tm);
		dpos     = (PW+1)'(cur_pos_q[ci]) - (PW+1)'(prev_pos_q[ci]);
		dpos_mag = dpos[PW] ? (PW+1)'(-dpos) : (PW+1)'(dpos);
		r_mag    = r_q[ci][34] ? 35'(-r_q[ci]) : 35'(r_q[ci]);
		pn       = tq[4] ? -prod_q : prod_q;
		term     = 36'(pn >>> 30);
		pabs     = prod_q[PRW-1] ? -prod_q : prod_q;

		ew = acc_q[0];
		if (ew > ONE_Q30)
			wc = ONE_Q30;
		else if (ew < -ONE_Q30)
			wc = -ONE_Q30;
		else
			wc = ew;
		xabs = wc[35] ? 31'(-wc) : 31'(wc);

		if (cz_q < 35'sd0)
			zc = 35'sd0;
		else if (cz_q > HALF_PI_Q30)
			zc = HALF_PI_Q30;
		else
			zc = cz_q;
		th = wneg_q ? PI_Q30 - zc : zc;
		a2 = th <<< 1;

		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_QMAC: begin
				mul_a = MA'(prev_quat_q[qt[3:2]]);
				mul_b = 34'(cur_quat_q[qt[1:0]]);
			end
			OP_SQMAC: begin
				mul_a = MA'(e_q[ci]);
				mul_b = 34'(e_q[ci]);
			end
			OP_WMUL: begin
				mul_a = MA'(xabs);
				mul_b = 34'(xabs);
			end
			OP_RMUL: begin
				mul_a = MA'(e_q[ci]);
				mul_b = 34'(angle_q);
			end
			OP_AMUL: begin
				mul_a = MA'(r_mag);
				mul_b = USEC_PER_SEC;
			end
			OP_LMUL: begin
				mul_a = MA'(dpos_mag);
				mul_b = USEC_PER_SEC;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase

		sq_sum = {1'b0, sq_res_q} + {1'b0, sq_one_q};
		sq_ge  = {1'b0, sq_v_q} >= sq_sum;

		cxs = cx_q >>> cor_i_q;
		cys = cy_q >>> cor_i_q;

		rem_sh = {dv_rem_q, dv_num_q[NW-1]};
		dv_ge  = rem_sh >= {1'b0, dv_den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= 1'b1;
			sq_cnt_q   <= '0;
			cor_busy_q <= 1'b0;
			dv_cnt_q   <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					cur_stamp_q    <= stamp_us;
					cur_pos_q[0]   <= pos_x;
					cur_pos_q[1]   <= pos_y;
					cur_pos_q[2]   <= pos_z;
					cur_quat_q[0]  <= quat_w;
					cur_quat_q[1]  <= quat_x;
					cur_quat_q[2]  <= quat_y;
					cur_quat_q[3]  <= quat_z;
				end
				OP_CHECK: begin
					for (int i = 0; i < 3; i++) begin
						res_lin_q[i] <= '0;
						res_ang_q[i] <= '0;
					end
					if (first_q) begin
						first_q      <= 1'b0;
						res_status_q <= ST_FIRST;
						res_stamp_q  <= '0;
						prev_stamp_q <= cur_stamp_q;
						prev_pos_q   <= cur_pos_q;
						prev_quat_q  <= cur_quat_q;
					end else begin
						res_stamp_q  <= cur_stamp_q;
						res_status_q <= (cur_stamp_q == prev_stamp_q) ? ST_ZERO_DT : ST_COMPUTED;
						dneg_q       <= cur_stamp_q < prev_stamp_q;
						dmag_q       <= (cur_stamp_q < prev_stamp_q) ?
							prev_stamp_q - cur_stamp_q : cur_stamp_q - prev_stamp_q;
					end
				end
				OP_QMAC: begin
					if (cmd.idx != 5'd0) begin
						if (tm[1:0] == 2'd0)
							acc_q[tm[3:2]] <= term;
						else
							acc_q[tm[3:2]] <= acc_q[tm[3:2]] + term;
					end
				end
				OP_QSAT: begin
					for (int i = 0; i < 3; i++)
						e_q[i] <= sat_e(acc_q[i+1]);
				end
				OP_SQMAC: begin
					if (cmd.idx == 5'd1)
						ss_q <= prod_q[63:0];
					else if (cmd.idx != 5'd0)
						ss_q <= ss_q + prod_q[63:0];
				end
				OP_SQRT_N: begin
					sq_v_q   <= ss_q;
					sq_res_q <= '0;
					sq_one_q <= SQRT_TOP;
					sq_cnt_q <= 6'd32;
				end
				OP_ST_N: norm_q <= sq_res_q[31:0];
				OP_WMUL: begin
					xabs_q <= xabs;
					wneg_q <= ew[35];
				end
				OP_SQRT_Y: begin
					sq_v_q   <= ONE_SQ_Q60 - prod_q[63:0];
					sq_res_q <= '0;
					sq_one_q <= SQRT_TOP;
					sq_cnt_q <= 6'd32;
				end
				OP_COR: begin
					cx_q       <= 35'(xabs_q);
					cy_q       <= 35'(sq_res_q[33:0]);
					cz_q       <= '0;
					cor_i_q    <= '0;
					cor_busy_q <= 1'b1;
				end
				OP_ANGLE: begin
					if (a2 > PI_Q30) begin
						angle_q <= TWO_PI_Q30 - a2;
						for (int i = 0; i < 3; i++)
							e_q[i] <= -e_q[i];
					end else begin
						angle_q <= a2;
					end
				end
				OP_DIV_L: begin
					dv_num_q <= prod_q[NW-1:0];
					dv_den_q <= DW'(dmag_q);
					dv_neg_q <= dpos[PW] ^ dneg_q;
					dv_rem_q <= '0;
					dv_cnt_q <= NCW'(NW);
				end
				OP_DIV_R: begin
					dv_num_q <= pabs[NW-1:0];
					dv_den_q <= DW'(norm_q);
					dv_neg_q <= prod_q[PRW-1];
					dv_rem_q <= '0;
					dv_cnt_q <= NCW'(NW);
				end
				OP_DIV_A: begin
					dv_num_q <= NW'(prod_q >>> 14);
					dv_den_q <= DW'(dmag_q);
					dv_neg_q <= r_q[ci][34] ^ dneg_q;
					dv_rem_q <= '0;
					dv_cnt_q <= NCW'(NW);
				end
				OP_ST_L: res_lin_q[ci] <= sat_rate(dv_quo_q, dv_neg_q);
				OP_ST_A: res_ang_q[ci] <= sat_rate(dv_quo_q, dv_neg_q);
				OP_ST_R: r_q[ci] <= dv_neg_q ? -35'(dv_quo_q[33:0]) : 35'(dv_quo_q[33:0]);
				OP_EMIT: begin
					out_stamp_us <= res_stamp_q;
					status       <= res_status_q;
					lin_x        <= res_lin_q[0];
					lin_y        <= res_lin_q[1];
					lin_z        <= res_lin_q[2];
					ang_x        <= res_ang_q[0];
					ang_y        <= res_ang_q[1];
					ang_z        <= res_ang_q[2];
					if (res_status_q == ST_COMPUTED) begin
						prev_stamp_q <= cur_stamp_q;
						prev_pos_q   <= cur_pos_q;
						prev_quat_q  <= cur_quat_q;
					end
				end
				default: ;
			endcase

			if (cmd.op == OP_QMAC || cmd.op == OP_SQMAC || cmd.op == OP_WMUL ||
			    cmd.op == OP_RMUL || cmd.op == OP_AMUL || cmd.op == OP_LMUL)
				prod_q <= mul_a * mul_b;

			// Square root, one result bit per cycle.
			if (sq_cnt_q != 6'd0) begin
				if (sq_ge) begin
					sq_v_q   <= sq_v_q - sq_sum[63:0];
					sq_res_q <= (sq_res_q >> 1) + sq_one_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_one_q <= sq_one_q >> 2;
				sq_cnt_q <= sq_cnt_q - 6'd1;
			end

			// Vectoring CORDIC, one micro-rotation per cycle.
			if (cor_busy_q) begin
				if (cy_q > 35'sd0) begin
					cx_q <= cx_q + cys;
					cy_q <= cy_q - cxs;
					cz_q <= cz_q + 35'(atan_q30(cor_i_q));
				end else begin
					cx_q <= cx_q - cys;
					cy_q <= cy_q + cxs;
					cz_q <= cz_q - 35'(atan_q30(cor_i_q));
				end
				cor_i_q <= cor_i_q + 5'd1;
				if (cor_i_q == CORDIC_STEPS - 5'd1)
					cor_busy_q <= 1'b0;
			end

			// Restoring divider, one quotient bit per cycle.
			if (dv_cnt_q != '0) begin
				dv_rem_q <= dv_ge ? DW'(rem_sh - {1'b0, dv_den_q}) : DW'(rem_sh);
				dv_num_q <= dv_num_q << 1;
				dv_quo_q <= {dv_quo_q[NW-2:0], dv_ge};
				dv_cnt_q <= dv_cnt_q - NCW'(1);
			end
		end
	end

	assign sts.first      = first_q;
	assign sts.zero_dt    = cur_stamp_q == prev_stamp_q;
	assign sts.small_norm = norm_q <= NORM_EPS;
	assign sts.div_busy   = dv_cnt_q != '0;
	assign sts.sqrt_busy  = sq_cnt_q != 6'd0;
	assign sts.cor_busy   = cor_busy_q;

endmodule

@@ src/ptd_ctrl.sv @@
`timescale 1ns / 1ps
module ptd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  ptd_pkg::sts_t sts,
	output ptd_pkg::cmd_t cmd
);
	import ptd_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_LMUL, S_LDIV, S_LWAIT, S_LST, S_QMAC, S_QSAT, S_SQMAC,
		S_NGO, S_NWAIT, S_NST, S_NCHK, S_WMUL, S_YGO, S_YWAIT, S_COR, S_CWAIT,
		S_ANGLE, S_RMUL, S_RDIV, S_RWAIT, S_RST, S_AMUL, S_ADIV, S_AWAIT, S_AST,
		S_FINISH
	} state_t;

	state_t     state_q;
	logic [4:0] idx_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = state_q == S_IDLE;
	assign m_tvalid  = out_valid_q;

	always_comb begin
		cmd.idx = idx_q;
		case (state_q)
			S_IDLE:   cmd.op = s_tvalid ? OP_LOAD : OP_NONE;
			S_CHECK:  cmd.op = OP_CHECK;
			S_LMUL:   cmd.op = OP_LMUL;
			S_LDIV:   cmd.op = OP_DIV_L;
			S_LST:    cmd.op = OP_ST_L;
			S_QMAC:   cmd.op = OP_QMAC;
			S_QSAT:   cmd.op = OP_QSAT;
			S_SQMAC:  cmd.op = OP_SQMAC;
			S_NGO:    cmd.op = OP_SQRT_N;
			S_NST:    cmd.op = OP_ST_N;
			S_WMUL:   cmd.op = OP_WMUL;
			S_YGO:    cmd.op = OP_SQRT_Y;
			S_COR:    cmd.op = OP_COR;
			S_ANGLE:  cmd.op = OP_ANGLE;
			S_RMUL:   cmd.op = OP_RMUL;
			S_RDIV:   cmd.op = OP_DIV_R;
			S_RST:    cmd.op = OP_ST_R;
			S_AMUL:   cmd.op = OP_AMUL;
			S_ADIV:   cmd.op = OP_DIV_A;
			S_AST:    cmd.op = OP_ST_A;
			S_FINISH: cmd.op = slot_free ? OP_EMIT : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FINISH && slot_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_CHECK;
				S_CHECK: begin
					idx_q   <= '0;
					state_q <= (sts.first || sts.zero_dt) ? S_FINISH : S_LMUL;
				end
				S_LMUL:  state_q <= S_LDIV;
				S_LDIV:  state_q <= S_LWAIT;
				S_LWAIT: if (!sts.div_busy) state_q <= S_LST;
				S_LST: begin
					if (idx_q == E_LAST) begin
						idx_q   <= '0;
						state_q <= S_QMAC;
					end else begin
						idx_q   <= idx_q + 5'd1;
						state_q <= S_LMUL;
					end
				end
				S_QMAC: begin
					if (idx_q == Q_TERMS) begin
						idx_q   <= '0;
						state_q <= S_QSAT;
					end else begin
						idx_q <= idx_q + 5'd1;
					end
				end
				S_QSAT: state_q <= S_SQMAC;
				S_SQMAC: begin
					if (idx_q == E_LAST + 5'd1) begin
						idx_q   <= '0;
						state_q <= S_NGO;
					end else begin
						idx_q <= idx_q + 5'd1;
					end
				end
				S_NGO:   state_q <= S_NWAIT;
				S_NWAIT: if (!sts.sqrt_busy) state_q <= S_NST;
				S_NST:   state_q <= S_NCHK;
				S_NCHK:  state_q <= sts.small_norm ? S_FINISH : S_WMUL;
				S_WMUL:  state_q <= S_YGO;
				S_YGO:   state_q <= S_YWAIT;
				S_YWAIT: if (!sts.sqrt_busy) state_q <= S_COR;
				S_COR:   state_q <= S_CWAIT;
				S_CWAIT: if (!sts.cor_busy) state_q <= S_ANGLE;
				S_ANGLE: state_q <= S_RMUL;
				S_RMUL:  state_q <= S_RDIV;
				S_RDIV:  state_q <= S_RWAIT;
				S_RWAIT: if (!sts.div_busy) state_q <= S_RST;
				S_RST:   state_q <= S_AMUL;
				S_AMUL:  state_q <= S_ADIV;
				S_ADIV:  state_q <= S_AWAIT;
				S_AWAIT: if (!sts.div_busy) state_q <= S_AST;
				S_AST: begin
					if (idx_q == E_LAST) begin
						idx_q   <= '0;
						state_q <= S_FINISH;
					end else begin
						idx_q   <= idx_q + 5'd1;
						state_q <= S_RMUL;
					end
				end
				S_FINISH: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A new word is never written over one that is still waiting.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |-> (!out_valid_q || m_tready))
		else $error("result written while output word still pending");

	// The first pose and a repeated stamp skip all arithmetic.
	a_short_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && (sts.first || sts.zero_dt)) |=> (state_q == S_FINISH))
		else $error("short path did not go straight to output");

	// The shared divider is only started when idle.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DIV_L || cmd.op == OP_DIV_R || cmd.op == OP_DIV_A) |-> !sts.div_busy)
		else $error("divider restarted while busy");

endmodule

@@ src/pose_twist_differentiator_top.sv @@
`timescale 1ns / 1ps
// The first pose or a repeated stamp goes from S_CHECK straight to S_FINISH; a computed pose
// at default widths runs nine 64-step divisions on the shared restoring divider, plus two
// 32-step square roots and a 30-step CORDIC (three divisions and one square root when the
// rotation is tiny). Only one pose is in flight at a time.
// Reset: arst_n clears the controller and marks the next pose as the first one.
module pose_twist_differentiator_top #(
	parameter int STAMP_WIDTH = 48,
	parameter int POS_WIDTH   = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// stamp_us, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
	input  logic [((STAMP_WIDTH + 3 * POS_WIDTH + 128 + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// out_stamp_us, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z
	output logic [((STAMP_WIDTH + 192 + 7) / 8) * 8 - 1:0] m_tdata,
	// status
	output logic [1:0]              m_tuser
);
	import ptd_pkg::*;

	localparam int OUT_TDATA_W = ((STAMP_WIDTH + 192 + 7) / 8) * 8;
	localparam int QB          = STAMP_WIDTH + 3 * POS_WIDTH;

	cmd_t cmd;
	sts_t sts;

	logic [STAMP_WIDTH-1:0] out_stamp_us;
	logic signed [31:0]     lin_x, lin_y, lin_z, ang_x, ang_y, ang_z;

	ptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptd_datapath #(
		.SW (STAMP_WIDTH),
		.PW (POS_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.stamp_us     (s_tdata[STAMP_WIDTH-1:0]),
		.pos_x        (s_tdata[STAMP_WIDTH +: POS_WIDTH]),
		.pos_y        (s_tdata[STAMP_WIDTH + POS_WIDTH +: POS_WIDTH]),
		.pos_z        (s_tdata[STAMP_WIDTH + 2 * POS_WIDTH +: POS_WIDTH]),
		.quat_w       (s_tdata[QB +: 32]),
		.quat_x       (s_tdata[QB + 32 +: 32]),
		.quat_y       (s_tdata[QB + 64 +: 32]),
		.quat_z       (s_tdata[QB + 96 +: 32]),
		.out_stamp_us (out_stamp_us),
		.lin_x        (lin_x),
		.lin_y        (lin_y),
		.lin_z        (lin_z),
		.ang_x        (ang_x),
		.ang_y        (ang_y),
		.ang_z        (ang_z),
		.status       (m_tuser)
	);

	assign m_tdata = OUT_TDATA_W'({ang_z, ang_y, ang_x, lin_z, lin_y, lin_x, out_stamp_us});

endmodule
